// ===== rtl/core/idm_pkg.sv =====
// shared types and constants for the car-following step pipeline
// no dependencies
package idm_pkg;

  localparam int unsigned QW      = 20;  // quotient bits per divider
  localparam int unsigned GNW     = 47;  // desired gap dividend, 2^-32 m
  localparam int unsigned GDW     = 33;  // clamped gap shifted left by 7
  localparam int unsigned SNW     = 32;  // speed shifted into Q16
  localparam int unsigned SDW     = 16;  // floored desired speed
  localparam int unsigned LATENCY = 28;

  localparam logic [16:0] HEADWAY_Q16   = 17'd85197;
  localparam logic [13:0] INV_2SQRT_Q16 = 14'd14207;
  localparam logic [46:0] MIN_GAP_Q32   = 47'd10307921510;
  localparam logic [25:0] GAP_FLOOR_Q9  = 26'd179;
  localparam logic [15:0] V0_FLOOR_Q8   = 16'd26;
  localparam logic [9:0]  AMAX_Q8       = 10'd486;
  localparam logic [19:0] RATIO_SAT_Q16 = 20'h80000;
  localparam logic [19:0] SR_SAT_Q16    = 20'h20000;

  typedef struct packed {
    logic [23:0] own_position;
    logic [15:0] own_speed;
    logic [15:0] cruise_speed;
    logic [11:0] own_length;
    logic        leader_present;
    logic [23:0] leader_position;
    logic [11:0] leader_length;
    logic [15:0] leader_speed;
    logic [23:0] stop_line_position;
    logic        light_open;
    logic [12:0] step_time;
  } idm_req_t;

  typedef struct packed {
    logic [15:0]        new_speed;
    logic [23:0]        new_position;
    logic signed [11:0] accel_applied;
  } idm_res_t;

  // fields that ride along the dividers
  typedef struct packed {
    logic        constrained;
    logic [15:0] v;
    logic [12:0] dt;
    logic [23:0] op;
  } idm_side_t;

  typedef struct packed {
    logic [GNW-1:0] gn;
    logic [GDW-1:0] gd;
    logic [SNW-1:0] sn;
    logic [SDW-1:0] sd;
  } idm_div_in_t;

  typedef struct packed {
    logic [QW-1:0] gq;
    logic          govf;
    logic [QW-1:0] sq;
    logic          sovf;
  } idm_div_res_t;

endpackage

// ===== rtl/core/idm_car_following_step.sv =====
// car-following step, one vehicle request per cycle, fully pipelined
// an accepted request passes the front, divider and back stages to done_o; throughput one per cycle
// the two 20-stage dividers set the depth; busy stays low, results are never held off
// reset clears only the valid bits, payload stages are left as they are
module idm_car_following_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  idm_pkg::idm_req_t req_i,
  output logic              busy,
  output logic              done_o,
  output idm_pkg::idm_res_t res_o
);

  logic                  f_valid, d_valid;
  idm_pkg::idm_div_in_t  f_div;
  idm_pkg::idm_side_t    f_side, d_side;
  idm_pkg::idm_div_res_t d_res;

  assign busy = 1'b0;

  idm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .req_i   (req_i),
    .valid_o (f_valid),
    .div_o   (f_div),
    .side_o  (f_side)
  );

  idm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .div_i   (f_div),
    .side_i  (f_side),
    .valid_o (d_valid),
    .res_o   (d_res),
    .side_o  (d_side)
  );

  idm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .div_i   (d_res),
    .side_i  (d_side),
    .valid_o (done_o),
    .res_o   (res_o)
  );

endmodule

// ===== rtl/core/idm_front.sv =====
// front stages: gap selection, desired gap products, divider operands
// depends on idm_pkg
module idm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  idm_pkg::idm_req_t    req_i,
  output logic                 valid_o,
  output idm_pkg::idm_div_in_t div_o,
  output idm_pkg::idm_side_t   side_o
);

  logic signed [27:0] gl, lg, gap;
  logic signed [16:0] dv;
  logic               cons, stop_hit;
  logic [25:0]        gc;
  logic signed [33:0] m1;
  logic [32:0]        h;
  logic [15:0]        v0c;

  logic                a_valid_q;
  logic signed [33:0]  m1_q;
  logic [32:0]         h_q;
  logic [25:0]         gc_q;
  logic [15:0]         v0c_q;
  idm_pkg::idm_side_t  a_side_q;

  logic signed [48:0]  p;
  logic signed [49:0]  dyn;
  logic [46:0]         sdes;

  always_comb begin
    gl = $signed({3'b0, req_i.leader_position, 1'b0}) - $signed({16'b0, req_i.leader_length})
       - $signed({3'b0, req_i.own_position, 1'b0}) - $signed({16'b0, req_i.own_length});
    lg = $signed({3'b0, req_i.stop_line_position, 1'b0})
       - $signed({3'b0, req_i.own_position, 1'b0}) - $signed({16'b0, req_i.own_length});
    stop_hit = (req_i.own_position < req_i.stop_line_position) && !req_i.light_open;
    gap  = '0;
    dv   = '0;
    cons = 1'b0;
    if (req_i.leader_present) begin
      gap  = gl;
      dv   = $signed({1'b0, req_i.own_speed}) - $signed({1'b0, req_i.leader_speed});
      cons = 1'b1;
    end
    // red light ahead acts as a standing obstacle when there is no leader or it is nearer than the leader
    if (stop_hit && (!req_i.leader_present || lg < gl)) begin
      gap  = lg;
      dv   = $signed({1'b0, req_i.own_speed});
      cons = 1'b1;
    end
    gc  = (gap < $signed({2'b0, idm_pkg::GAP_FLOOR_Q9})) ? idm_pkg::GAP_FLOOR_Q9 : gap[25:0];
    m1  = $signed({1'b0, req_i.own_speed}) * dv;
    h   = 33'(req_i.own_speed) * 33'(idm_pkg::HEADWAY_Q16);
    v0c = (req_i.cruise_speed < idm_pkg::V0_FLOOR_Q8) ? idm_pkg::V0_FLOOR_Q8
                                                     : req_i.cruise_speed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q                 <= m1;
    h_q                  <= h;
    gc_q                 <= gc;
    v0c_q                <= v0c;
    a_side_q.constrained <= cons;
    a_side_q.v           <= req_i.own_speed;
    a_side_q.dt          <= req_i.step_time;
    a_side_q.op          <= req_i.own_position;
  end

  always_comb begin
    p    = m1_q * $signed({1'b0, idm_pkg::INV_2SQRT_Q16});
    dyn  = $signed({9'b0, h_q, 8'b0}) + p;
    sdes = idm_pkg::MIN_GAP_Q32 + ((dyn < 0) ? 47'd0 : dyn[46:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div_o.gn <= sdes;
    div_o.gd <= {gc_q, 7'b0};
    div_o.sn <= {a_side_q.v, 16'b0};
    div_o.sd <= v0c_q;
    side_o   <= a_side_q;
  end

endmodule

// ===== rtl/core/idm_div.sv =====
// two pipelined restoring dividers, one quotient bit per stage
// depends on idm_pkg
module idm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  idm_pkg::idm_div_in_t  div_i,
  input  idm_pkg::idm_side_t    side_i,
  output logic                  valid_o,
  output idm_pkg::idm_div_res_t res_o,
  output idm_pkg::idm_side_t    side_o
);

  localparam int unsigned QW = idm_pkg::QW;
  localparam int unsigned GW = idm_pkg::GDW + QW;
  localparam int unsigned SW = idm_pkg::SDW + QW;

  logic [GW-1:0]      g_r_q [QW+1];
  logic [GW-1:0]      g_d_q [QW+1];
  logic [QW-1:0]      g_q_q [QW+1];
  logic               g_o_q [QW+1];
  logic [SW-1:0]      s_r_q [QW+1];
  logic [SW-1:0]      s_d_q [QW+1];
  logic [QW-1:0]      s_q_q [QW+1];
  logic               s_o_q [QW+1];
  logic               v_q   [QW+1];
  idm_pkg::idm_side_t sd_q  [QW+1];

  // entry stage: quotients of 2^QW or more are flagged and later saturated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    g_r_q[0] <= GW'(div_i.gn);
    g_d_q[0] <= GW'(div_i.gd);
    g_q_q[0] <= '0;
    g_o_q[0] <= GW'(div_i.gn) >= (GW'(div_i.gd) << QW);
    s_r_q[0] <= SW'(div_i.sn);
    s_d_q[0] <= SW'(div_i.sd);
    s_q_q[0] <= '0;
    s_o_q[0] <= SW'(div_i.sn) >= (SW'(div_i.sd) << QW);
    sd_q[0]  <= side_i;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned S = QW - 1 - k;
    logic [GW-1:0] g_sh;
    logic [SW-1:0] s_sh;
    logic          g_ge, s_ge;
    logic [QW-1:0] g_bit, s_bit;

    always_comb begin
      g_sh  = g_d_q[k] << S;
      s_sh  = s_d_q[k] << S;
      g_ge  = g_r_q[k] >= g_sh;
      s_ge  = s_r_q[k] >= s_sh;
      g_bit = QW'(g_ge) << S;
      s_bit = QW'(s_ge) << S;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      g_r_q[k+1] <= g_ge ? (g_r_q[k] - g_sh) : g_r_q[k];
      g_d_q[k+1] <= g_d_q[k];
      g_q_q[k+1] <= g_q_q[k] | g_bit;
      g_o_q[k+1] <= g_o_q[k];
      s_r_q[k+1] <= s_ge ? (s_r_q[k] - s_sh) : s_r_q[k];
      s_d_q[k+1] <= s_d_q[k];
      s_q_q[k+1] <= s_q_q[k] | s_bit;
      s_o_q[k+1] <= s_o_q[k];
      sd_q[k+1]  <= sd_q[k];
    end
  end

  assign valid_o    = v_q[QW];
  assign res_o.gq   = g_q_q[QW];
  assign res_o.govf = g_o_q[QW];
  assign res_o.sq   = s_q_q[QW];
  assign res_o.sovf = s_o_q[QW];
  assign side_o     = sd_q[QW];

endmodule

// ===== rtl/core/idm_back.sv =====
// back stages: ratio powers, acceleration clamp, speed and position update
// depends on idm_pkg
module idm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  idm_pkg::idm_div_res_t div_i,
  input  idm_pkg::idm_side_t    side_i,
  output logic                  valid_o,
  output idm_pkg::idm_res_t     res_o
);

  logic [19:0]        gr, sr;
  logic [39:0]        gsq, ssq;
  logic [22:0]        inter_q;
  logic [18:0]        sr2_q;
  logic               c_valid_q;
  idm_pkg::idm_side_t c_side_q;

  logic [37:0]        s4;
  logic signed [24:0] diff_q;
  logic               d_valid_q;
  idm_pkg::idm_side_t d_side_q;

  logic signed [34:0] acc24, acc24c;
  logic signed [11:0] acc_q;
  logic               e_valid_q;
  idm_pkg::idm_side_t e_side_q;

  logic signed [25:0] adt;
  logic signed [33:0] vs, vr;
  logic [15:0]        nv;
  logic [15:0]        nv_q;
  logic signed [11:0] f_acc_q;
  logic               f_valid_q;
  idm_pkg::idm_side_t f_side_q;

  logic [29:0]        adv;
  logic [24:0]        np;

  // stage c: saturate ratios and square them
  always_comb begin
    gr  = (div_i.govf || div_i.gq > idm_pkg::RATIO_SAT_Q16) ? idm_pkg::RATIO_SAT_Q16 : div_i.gq;
    sr  = (div_i.sovf || div_i.sq > idm_pkg::SR_SAT_Q16) ? idm_pkg::SR_SAT_Q16 : div_i.sq;
    gsq = 40'(gr) * 40'(gr);
    ssq = 40'(sr) * 40'(sr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      c_valid_q <= valid_i;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      valid_o   <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inter_q  <= side_i.constrained ? gsq[38:16] : '0;
    sr2_q    <= ssq[34:16];
    c_side_q <= side_i;
  end

  // stage d: fourth power and free-road minus interaction
  always_comb begin
    s4 = 38'(sr2_q) * 38'(sr2_q);
  end

  always_ff @(posedge clk_i) begin
    diff_q   <= 25'sd65536 - $signed({4'b0, s4[36:16]}) - $signed({2'b0, inter_q});
    d_side_q <= c_side_q;
  end

  // stage e: scale, clamp in q24, floor to q8
  always_comb begin
    acc24  = diff_q * $signed({1'b0, idm_pkg::AMAX_Q8});
    acc24c = acc24;
    if (acc24 > $signed({9'b0, idm_pkg::AMAX_Q8, 16'b0})) begin
      acc24c = $signed({9'b0, idm_pkg::AMAX_Q8, 16'b0});
    end
    if (acc24 < -35'sd134217728) begin
      acc24c = -35'sd134217728;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc24c[27:0 + 16];
    e_side_q <= d_side_q;
  end

  // stage f: speed integration, rounded half up, floored at zero, saturated at full scale
  always_comb begin
    adt = acc_q * $signed({1'b0, e_side_q.dt});
    vs  = $signed({2'b0, e_side_q.v, 16'b0}) + adt;
    vr  = vs + 34'sd32768;
    nv  = '0;
    if (vs > 0) begin
      nv = (vr[33:16] > 18'd65535) ? 16'hFFFF : vr[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    nv_q     <= nv;
    f_acc_q  <= acc_q;
    f_side_q <= e_side_q;
  end

  // stage g: position advance with saturation
  always_comb begin
    adv = 30'(nv_q) * 30'(f_side_q.dt) + 30'd32768;
    np  = 25'(f_side_q.op) + 25'(adv[29:16]);
  end

  always_ff @(posedge clk_i) begin
    res_o.new_speed     <= nv_q;
    res_o.new_position  <= np[24] ? 24'hFFFFFF : np[23:0];
    res_o.accel_applied <= f_acc_q;
  end

endmodule

// ===== rtl/core/idm_checker.sv =====
// port-level checks for the car-following step
// depends on idm_pkg; bound to idm_car_following_step
module idm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input idm_pkg::idm_req_t req_i,
  input logic              busy,
  input logic              done_o,
  input idm_pkg::idm_res_t res_o
);

  localparam int unsigned LAT = idm_pkg::LATENCY;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without matching request");

  a_accel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.accel_applied <= 12'sd486)
    else $error("acceleration above limit");

  a_position_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.new_position >= $past(req_i.own_position, LAT))
    else $error("position moved backward");

endmodule

bind idm_car_following_step idm_checker u_idm_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .req_i  (req_i),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

// ===== bench/idm_car_following_step_tb.sv =====
// testbench for the car-following step pipeline: directed and random vehicle requests
// checked field by field against an in-bench predictor; depends on idm_pkg and the block
`timescale 1ns / 100ps

module idm_car_following_step_tb;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  idm_pkg::idm_req_t req_i;
  logic              busy;
  logic              done_o;
  idm_pkg::idm_res_t res_o;

  idm_pkg::idm_res_t pending_q[$];
  int                n_mismatch;
  int                n_checked;
  int                n_sent;
  int                idle_cycles;
  bit                timed_out;

  idm_car_following_step dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // integer form of the car-following update
  function automatic idm_pkg::idm_res_t idm_update(idm_pkg::idm_req_t r);
    longint op, v, v0, ol, lp, ll, lv, sl, dt;
    longint gap, dv, inter, dyn, gc, v0c, freer, acc24, acc, vs, nv, np, adv;
    longint unsigned sdes, ratio, sr, sr2, sr4;
    bit constrained;
    idm_pkg::idm_res_t o;
    op = r.own_position; v = r.own_speed; v0 = r.cruise_speed; ol = r.own_length;
    lp = r.leader_position; ll = r.leader_length; lv = r.leader_speed;
    sl = r.stop_line_position; dt = r.step_time;
    constrained = 1'b0; gap = 0; dv = 0;
    if (r.leader_present) begin
      gap = 2 * lp - ll - 2 * op - ol;
      dv = v - lv;
      constrained = 1'b1;
    end
    // red light acts as a standing obstacle while still before the line
    if (op < sl && !r.light_open) begin
      if (!constrained || (2 * sl - 2 * op - ol) < gap) begin
        gap = 2 * sl - 2 * op - ol;
        dv = v;
        constrained = 1'b1;
      end
    end
    inter = 0;
    if (constrained) begin
      dyn = v * 85197 * 256 + v * dv * 14207;
      if (dyn < 0) dyn = 0;
      sdes = 64'd10307921510 + dyn;
      gc = gap < 179 ? 179 : gap;
      ratio = sdes / (longint'(gc) << 7);
      if (ratio > (64'd8 << 16)) ratio = 64'd8 << 16;
      inter = (ratio * ratio) >> 16;
    end
    v0c = v0 < 26 ? 26 : v0;
    sr = (longint'(v) << 16) / v0c;
    if (sr > (64'd2 << 16)) sr = 64'd2 << 16;
    sr2 = (sr * sr) >> 16;
    sr4 = (sr2 * sr2) >> 16;
    freer = 65536 - longint'(sr4);
    acc24 = 486 * (freer - inter);
    if (acc24 > (64'sd486 << 16)) acc24 = 64'sd486 << 16;
    if (acc24 < -(64'sd2048 << 16)) acc24 = -(64'sd2048 << 16);
    acc = ((acc24 + (64'sd2048 << 16)) >>> 16) - 2048;
    vs = v * 65536 + acc * dt;
    nv = 0;
    if (vs > 0) begin
      nv = (vs + 32768) >>> 16;
      if (nv > 65535) nv = 65535;
    end
    adv = (nv * dt + 32768) >>> 16;
    np = op + adv;
    if (np > 64'hFFFFFF) np = 64'hFFFFFF;
    o.new_speed = nv[15:0];
    o.new_position = np[23:0];
    o.accel_applied = acc[11:0];
    return o;
  endfunction

  function automatic idm_pkg::idm_req_t random_bits();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(idm_pkg::idm_req_t)-1:0];
  endfunction

  task automatic send_request(idm_pkg::idm_req_t r);
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_q = {pending_q, idm_update(r)};
    n_sent++;
    @(negedge clk_i);
    start <= 1'b0;
    req_i <= random_bits();
  endtask

  // send with a random gap; consecutive requests keep start high
  task automatic send_gapped(idm_pkg::idm_req_t r);
    int gap;
    gap = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(3, 40);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap == 0) begin
      @(negedge clk_i);
      start <= 1'b1;
      req_i <= r;
      do @(posedge clk_i); while (busy);
      pending_q = {pending_q, idm_update(r)};
      n_sent++;
    end else begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
      start <= 1'b1;
      req_i <= r;
      do @(posedge clk_i); while (busy);
      pending_q = {pending_q, idm_update(r)};
      n_sent++;
    end
  endtask

  always @(posedge clk_i) begin
    idm_pkg::idm_res_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", res_o);
      end else begin
        exp_r = pending_q.pop_front();
        n_checked++;
        if (res_o.new_speed !== exp_r.new_speed || res_o.new_position !== exp_r.new_position
            || res_o.accel_applied !== exp_r.accel_applied) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp spd %0d pos %0d acc %0d, got spd %0d pos %0d acc %0d",
                     exp_r.new_speed, exp_r.new_position, exp_r.accel_applied,
                     res_o.new_speed, res_o.new_position, res_o.accel_applied);
        end
      end
    end
  end

  // watchdog on cycles with no request or result accepted
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic idm_pkg::idm_req_t random_vehicle();
    idm_pkg::idm_req_t r;
    r = random_bits();
    case ($urandom_range(0, 3))
      0: ;
      default: begin
        // plausible traffic: leader a bit ahead, stop line a bit ahead or just behind
        r.own_position = 24'($urandom_range(0, 24'hFF0000));
        r.own_speed = 16'($urandom_range(0, 12000));
        r.cruise_speed = 16'($urandom_range(0, 12000));
        r.leader_position = 24'(r.own_position + $urandom_range(0, 30000));
        r.stop_line_position = 24'(r.own_position + $urandom_range(0, 40000) - 2000);
        r.step_time = 13'($urandom_range(0, 6554));
      end
    endcase
    return r;
  endfunction

  task automatic test_extremes();
    idm_pkg::idm_req_t r;
    r = '0;
    send_request(r);
    r = '1;
    send_request(r);
    r = '0; r.cruise_speed = 16'd8000; r.own_speed = 16'd4000; r.step_time = 13'd6554;
    r.light_open = 1'b1;
    send_request(r);                          // free road
    r.leader_present = 1'b1; r.leader_position = 24'd2000; r.leader_length = 12'd1000;
    r.leader_speed = 16'd1000;
    send_request(r);                          // leader ahead
    r.leader_position = 24'd0;
    send_request(r);                          // leader overlapping
    r.own_position = 24'd100; r.leader_present = 1'b0; r.light_open = 1'b0;
    r.stop_line_position = 24'd3000;
    send_request(r);                          // red light ahead
    r.stop_line_position = 24'd50;
    send_request(r);                          // already past the line
    r.leader_present = 1'b1; r.leader_position = 24'd900000; r.stop_line_position = 24'd5000;
    send_request(r);                          // light nearer than leader
    r.cruise_speed = 16'd0; r.own_speed = 16'hFFFF;
    send_request(r);                          // speed ratio saturates
    r = '0; r.own_position = 24'hFFFFFF; r.own_speed = 16'hFFFF; r.cruise_speed = 16'hFFFF;
    r.step_time = 13'h1FFF; r.light_open = 1'b1;
    send_request(r);                          // position saturation at full speed
  endtask

  task automatic test_random_stream();
    repeat (2000) send_gapped(random_vehicle());
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic test_drain_pause();
    wait (pending_q.size() == 0);
    repeat (5) send_request(random_vehicle());
  endtask

  initial begin
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    n_mismatch = 0; n_checked = 0; n_sent = 0; idle_cycles = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_drain_pause();
    test_random_stream();
    wait (pending_q.size() == 0);
    repeat (idm_pkg::LATENCY + 10) @(posedge clk_i);
    $display("sent %0d vehicle requests, checked %0d results", n_sent, n_checked);
    $display("covered free road, leader, red light, overlap and saturation cases");
    if (n_mismatch == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
